>>> design/task_scheduler_with_sleep_timers_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the task scheduler
// ---------------------------------------------------------------------------
`ifndef TASK_SCHEDULER_WITH_SLEEP_TIMERS_TOP_DEFINES_SVH
`define TASK_SCHEDULER_WITH_SLEEP_TIMERS_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define TSCHED_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define TSCHED_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/tsched_pkg.sv
// ---------------------------------------------------------------------------
// tsched_pkg
// Types and constants shared by the task scheduler files.
// ---------------------------------------------------------------------------
`default_nettype none

package tsched_pkg;

    // Operation codes of a request
    typedef enum logic [1:0] {
        FN_CREATE = 2'd0,
        FN_TICK   = 2'd1,
        FN_DELAY  = 2'd2,
        FN_YIELD  = 2'd3
    } t_func;

    // Task state codes
    typedef enum logic [1:0] {
        ST_READY   = 2'd0,
        ST_WAITING = 2'd1,
        ST_RUNNING = 2'd2
    } t_tstat;

    // Status of a result
    localparam logic STS_OK   = 1'b0;
    localparam logic STS_FULL = 1'b1;

    // Request payload
    typedef struct packed {
        t_func       func;
        logic [7:0]  task_id;
        logic [7:0]  priority_req;
        logic [15:0] sleep_ticks;
    } t_req;

    // Result payload
    typedef struct packed {
        logic [2:0] running_index;
        logic [7:0] running_id;
        logic       status;
    } t_rsp;

    // One task table entry as held in memory
    typedef struct packed {
        t_tstat      tstat;
        logic [15:0] sleep;
        logic [7:0]  prio;
        logic [7:0]  ident;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Idle task entry after reset
    localparam t_entry IDLE_ENTRY = '{tstat: ST_READY, sleep: 16'd0, prio: 8'd0, ident: 8'd0};

endpackage

`default_nettype wire

>>> design/tsched_ram.sv
// ---------------------------------------------------------------------------
// tsched_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module tsched_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> design/task_scheduler_with_sleep_timers_top.sv
// ---------------------------------------------------------------------------
// task_scheduler_with_sleep_timers_top
// Task scheduler: task table in one RAM, swept one entry per cycle.
// ---------------------------------------------------------------------------
// Channel   Direction  Signals                          Handshake
// request   in         i_in_valid, o_in_stall, i_in_req valid && !stall
// result    out        o_out_valid, i_out_stall, o_out_rsp valid && !stall
// config    in         i_cfg_valid, o_cfg_ready, i_cfg_data valid && ready
//
// A create passes through S_CREATE and S_OUT from acceptance to result.
// Tick, delay and yield sweep the N tasks in the table: the single RAM read
// port reads every entry once, then the chosen entry is read again in S_PICK
// and marked running in S_MARK before S_OUT.
// Reset (synchronous, active low) leaves only the idle task, in round robin.
// A waiting result holds in the output register; the next request is taken
// meanwhile and completes once the register frees.
// ---------------------------------------------------------------------------
`default_nettype none

module task_scheduler_with_sleep_timers_top #(
    parameter int MAX_TASKS = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire tsched_pkg::t_req  i_in_req,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output tsched_pkg::t_rsp       o_out_rsp,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic              i_cfg_data
);

    localparam int IW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int XW = IW + 3;
    localparam int ENTRY_W_L = tsched_pkg::ENTRY_W;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CREATE = 6'b000010,
        S_SCAN   = 6'b000100,
        S_PICK   = 6'b001000,
        S_MARK   = 6'b010000,
        S_OUT    = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic              r_mode;
    logic [CW-1:0]     r_count, n_count;
    logic [IW-1:0]     r_cur, n_cur;
    logic [7:0]        r_cur_id, n_cur_id;
    tsched_pkg::t_req  r_req, n_req;
    logic              r_status, n_status;
    logic              r_e0_set;

    // Sweep control
    logic              r_issue, n_issue;
    logic [IW-1:0]     r_ridx, n_ridx;
    logic              r_dvld, n_dvld;
    logic [IW-1:0]     r_didx, n_didx;
    logic [IW-1:0]     r_rd_idx;

    // Candidates gathered during the sweep
    logic              r_aft_v, n_aft_v;
    logic [IW-1:0]     r_aft, n_aft;
    logic              r_any_v, n_any_v;
    logic [IW-1:0]     r_any, n_any;
    logic              r_best_v, n_best_v;
    logic [IW-1:0]     r_best, n_best;
    logic [7:0]        r_best_prio, n_best_prio;

    // Output register
    logic              r_out_valid, n_out_valid;
    tsched_pkg::t_rsp  r_out, n_out;

    // RAM signals
    logic              ram_we, ram_re;
    logic [IW-1:0]     ram_waddr, ram_raddr;
    tsched_pkg::t_entry ram_wdata, ram_q, ent, upd;
    logic [ENTRY_W_L-1:0] ram_q_raw;

    logic [IW-1:0]     last_idx, chosen;
    logic              in_acc, out_free;
    logic [XW-1:0]     cur_ext;

    tsched_ram #(
        .WIDTH (ENTRY_W_L),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q_raw)
    );

    assign ram_q = tsched_pkg::t_entry'(ram_q_raw);

    // Substitute the idle task's reset value until entry 0 is first written
    assign ent = (r_rd_idx == '0 && !r_e0_set) ? tsched_pkg::IDLE_ENTRY : ram_q;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign last_idx    = IW'(r_count - CW'(1));

    // Choose the next task from the gathered candidates
    always_comb begin
        if (r_mode) begin
            chosen = r_best_v ? r_best : '0;
        end else if (r_aft_v) begin
            chosen = r_aft;
        end else begin
            chosen = r_any_v ? r_any : '0;
        end
    end

    // Update one swept entry: count down on a tick, then retire the current task
    always_comb begin
        upd = ent;
        if (r_req.func == tsched_pkg::FN_TICK && ent.tstat == tsched_pkg::ST_WAITING) begin
            if (ent.sleep <= 16'd1) begin
                upd.sleep = 16'd0;
                upd.tstat = tsched_pkg::ST_READY;
            end else begin
                upd.sleep = ent.sleep - 16'd1;
            end
        end
        if (r_didx == r_cur) begin
            if (r_req.func == tsched_pkg::FN_DELAY) begin
                upd.sleep = (r_req.sleep_ticks == 16'd0) ? 16'd1 : r_req.sleep_ticks;
                upd.tstat = tsched_pkg::ST_WAITING;
            end else begin
                upd.tstat = tsched_pkg::ST_READY;
            end
        end
    end

    assign cur_ext = XW'(r_cur);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_cur       = r_cur;
        n_cur_id    = r_cur_id;
        n_req       = r_req;
        n_status    = r_status;
        n_issue     = r_issue;
        n_ridx      = r_ridx;
        n_dvld      = 1'b0;
        n_didx      = r_didx;
        n_aft_v     = r_aft_v;
        n_aft       = r_aft;
        n_any_v     = r_any_v;
        n_any       = r_any;
        n_best_v    = r_best_v;
        n_best      = r_best;
        n_best_prio = r_best_prio;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = upd;
        ram_re      = 1'b0;
        ram_raddr   = r_ridx;

        case (r_state)
            S_IDLE: begin
                // Take a request and start its work
                if (in_acc) begin
                    n_req    = i_in_req;
                    n_status = tsched_pkg::STS_OK;
                    n_issue  = 1'b1;
                    n_ridx   = '0;
                    n_aft_v  = 1'b0;
                    n_any_v  = 1'b0;
                    n_best_v = 1'b0;
                    if (i_in_req.func == tsched_pkg::FN_CREATE) begin
                        n_state = S_CREATE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_CREATE: begin
                // Append the new task, or refuse when the table is full
                if (r_count == CW'(MAX_TASKS)) begin
                    n_status = tsched_pkg::STS_FULL;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = IW'(r_count);
                    ram_wdata = '{tstat: tsched_pkg::ST_READY, sleep: 16'd0,
                                  prio: r_req.priority_req, ident: r_req.task_id};
                    n_count   = r_count + CW'(1);
                end
                n_state = S_OUT;
            end
            S_SCAN: begin
                // Issue the next read
                if (r_issue) begin
                    ram_re = 1'b1;
                    n_dvld = 1'b1;
                    n_didx = r_ridx;
                    if (r_ridx == last_idx) begin
                        n_issue = 1'b0;
                    end else begin
                        n_ridx = r_ridx + IW'(1);
                    end
                end
                // Write back the entry that arrived and track candidates
                if (r_dvld) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_didx;
                    ram_wdata = upd;
                    if (upd.tstat == tsched_pkg::ST_READY && r_didx != '0) begin
                        if (!r_any_v) begin
                            n_any_v = 1'b1;
                            n_any   = r_didx;
                        end
                        if (!r_aft_v && r_didx > r_cur) begin
                            n_aft_v = 1'b1;
                            n_aft   = r_didx;
                        end
                        if (!r_best_v || upd.prio > r_best_prio) begin
                            n_best_v    = 1'b1;
                            n_best      = r_didx;
                            n_best_prio = upd.prio;
                        end
                    end
                    if (r_didx == last_idx) begin
                        n_state = S_PICK;
                    end
                end
            end
            S_PICK: begin
                // Read the chosen entry back
                ram_re    = 1'b1;
                ram_raddr = chosen;
                n_cur     = chosen;
                n_state   = S_MARK;
            end
            S_MARK: begin
                // Mark the chosen task running
                ram_we          = 1'b1;
                ram_waddr       = r_cur;
                ram_wdata       = ent;
                ram_wdata.tstat = tsched_pkg::ST_RUNNING;
                n_cur_id        = ent.ident;
                n_state         = S_OUT;
            end
            S_OUT: begin
                // Hand the result to the output register once it is free
                if (out_free) begin
                    n_out_valid             = 1'b1;
                    n_out.running_index     = cur_ext[2:0];
                    n_out.running_id        = r_cur_id;
                    n_out.status            = r_status;
                    n_state                 = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= 1'b0;
            r_count     <= CW'(1);
            r_cur       <= '0;
            r_cur_id    <= 8'd0;
            r_e0_set    <= 1'b0;
            r_issue     <= 1'b0;
            r_dvld      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cur       <= n_cur;
            r_cur_id    <= n_cur_id;
            r_issue     <= n_issue;
            r_dvld      <= n_dvld;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= i_cfg_data;
            end
            if (ram_we && ram_waddr == '0) begin
                r_e0_set <= 1'b1;
            end
        end
    end

    // Payload and datapath registers
    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_status    <= n_status;
        r_ridx      <= n_ridx;
        r_didx      <= n_didx;
        r_aft_v     <= n_aft_v;
        r_aft       <= n_aft;
        r_any_v     <= n_any_v;
        r_any       <= n_any;
        r_best_v    <= n_best_v;
        r_best      <= n_best;
        r_best_prio <= n_best_prio;
        r_out       <= n_out;
        if (ram_re) begin
            r_rd_idx <= ram_raddr;
        end
    end

endmodule

`default_nettype wire

>>> design/tsched_chk.sv
// ---------------------------------------------------------------------------
// tsched_chk
// Port-level checks on the task scheduler, bound to its top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "task_scheduler_with_sleep_timers_top_defines.svh"

module tsched_chk #(
    parameter int MAX_TASKS = 8
) (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             o_in_stall,
    input wire tsched_pkg::t_req i_in_req,
    input wire logic             o_out_valid,
    input wire logic             i_out_stall,
    input wire tsched_pkg::t_rsp o_out_rsp
);

    localparam bit SMALL_TABLE = (MAX_TASKS <= 8);

    logic in_acc;
    logic ok_create;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign ok_create = (i_in_req.func == tsched_pkg::FN_CREATE);

    // A held result keeps its payload
    `TSCHED_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_rsp), "result changed while stalled")

    // The scheduler works on one request at a time
    `TSCHED_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, in_acc, o_in_stall, "request taken back to back")

    // For tables of up to eight tasks, the idle task carries identifier zero
    `TSCHED_ASSERT_NOW(a_idle_id, i_clk, i_rst_n, SMALL_TABLE && o_out_valid && o_out_rsp.running_index == 3'd0, o_out_rsp.running_id == 8'd0, "idle task shows a nonzero identifier")

    // A running index stays inside the table
    `TSCHED_ASSERT_NOW(a_index_range, i_clk, i_rst_n, SMALL_TABLE && o_out_valid && ok_create == ok_create, 32'(o_out_rsp.running_index) < MAX_TASKS, "running index beyond the table")

endmodule

bind task_scheduler_with_sleep_timers_top tsched_chk #(
    .MAX_TASKS (MAX_TASKS)
) u_tsched_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_req    (i_in_req),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_rsp   (o_out_rsp)
);

`default_nettype wire
